// ===== hdl/ugadj_pkg.sv =====
// Shared types and constants for the undirected graph adjacency table.
package ugadj_pkg;

  localparam int CMD_W     = 2;
  localparam int NODE_W    = 4;
  localparam int CNT_W     = 5;
  localparam int STAT_W    = 3;
  localparam int NODE_SPAN = 16;

  localparam logic [CMD_W-1:0] CMD_ADD_EDGE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REM_EDGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REM_NODE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LIST     = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISSING   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_CONNECTED = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NO_EDGE   = 3'd3;
  localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd4;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_WR_B,
    S_SWEEP,
    S_LIST,
    S_RESP
  } ug_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;
    logic              rd_a;
    logic              rd_b;
    logic              wr_a;
    logic              wr_b;
    logic              kill;
    logic              sweep;
    logic              load_list;
    logic              set_status;
    logic [STAT_W-1:0] status_val;
    logic              emit_single;
    logic              emit_list;
  } ug_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [STAT_W-1:0] pre_st;
    logic [CMD_W-1:0]  cmd;
    logic              bit_ab;
    logic              row_empty;
    logic              sweep_done;
    logic              out_free;
    logic              pend_last;
  } ug_stat_t;

endpackage

// ===== hdl/ugadj_dp.sv =====
// Datapath: adjacency memory, alive flags, checks, neighbor list and result register.
module ugadj_dp #(
  parameter int MAX_NODES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [ugadj_pkg::CNT_W-1:0]  cfg_wr_data,
  input  logic [ugadj_pkg::CMD_W-1:0]  in_cmd,
  input  logic [ugadj_pkg::NODE_W-1:0] in_node_a,
  input  logic [ugadj_pkg::NODE_W-1:0] in_node_b,
  input  ugadj_pkg::ug_cmd_t         ctl,
  output ugadj_pkg::ug_stat_t        sts,
  input  logic                       out_tready,
  output logic                       out_tvalid,
  output logic [ugadj_pkg::STAT_W-1:0] out_status,
  output logic [ugadj_pkg::NODE_W-1:0] out_neighbor,
  output logic                       out_neighbor_valid,
  output logic                       out_last
);
  import ugadj_pkg::*;

  localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int SW_W  = $clog2(MAX_NODES + 1);
  localparam int EXT_W = (MAX_NODES > NODE_SPAN) ? MAX_NODES : NODE_SPAN;
  localparam logic [SW_W-1:0] SW_END = SW_W'(MAX_NODES);

  logic [MAX_NODES-1:0] rows_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_vld_r;
  logic [MAX_NODES-1:0] alive_r;
  logic [CNT_W-1:0]     node_count_r;
  logic [CMD_W-1:0]     cmd_r;
  logic [NODE_W-1:0]    a_r;
  logic [NODE_W-1:0]    b_r;
  logic [MAX_NODES-1:0] rd_q_r;
  logic                 rd_hit_r;
  logic [SW_W-1:0]      sw_cnt_r;
  logic [NODE_SPAN-1:0] pend_r;
  logic [STAT_W-1:0]    status_r;
  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [NODE_W-1:0]    out_neighbor_r;
  logic                 out_nvalid_r;
  logic                 out_last_r;

  logic [IDX_W-1:0]     a_idx;
  logic [IDX_W-1:0]     b_idx;
  logic                 a_ok;
  logic                 b_ok;
  logic                 edge_cmd;
  logic [MAX_NODES-1:0] row_cur;
  logic [EXT_W-1:0]     row_ext;
  logic [NODE_SPAN-1:0] row_vis;
  logic [MAX_NODES-1:0] bit_a_vec;
  logic [MAX_NODES-1:0] bit_b_vec;
  logic [STAT_W-1:0]    pre_st;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [MAX_NODES-1:0] wr_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 sw_done;
  logic [NODE_SPAN-1:0] pend_rest;
  logic [NODE_W-1:0]    low_idx;
  logic                 out_free;

  assign a_idx     = IDX_W'(a_r);
  assign b_idx     = IDX_W'(b_r);
  assign a_ok      = ({1'b0, a_r} < node_count_r) && (32'(a_r) < MAX_NODES);
  assign b_ok      = ({1'b0, b_r} < node_count_r) && (32'(b_r) < MAX_NODES);
  assign edge_cmd  = (cmd_r == CMD_ADD_EDGE) || (cmd_r == CMD_REM_EDGE);
  assign row_cur   = rd_hit_r ? rd_q_r : '0;
  assign row_ext   = EXT_W'(row_cur);
  assign bit_a_vec = MAX_NODES'(1) << a_idx;
  assign bit_b_vec = MAX_NODES'(1) << b_idx;
  assign sw_done   = (sw_cnt_r == SW_END);
  assign out_free  = !out_valid_r || out_tready;
  assign pend_rest = pend_r & (pend_r - 1'b1);

  // Only neighbors below the effective node count are listed.
  always_comb begin
    for (int i = 0; i < NODE_SPAN; i++) begin
      row_vis[i] = row_ext[i] && (CNT_W'(i) < node_count_r) && (i < MAX_NODES);
    end
  end

  always_comb begin
    low_idx = '0;
    for (int i = NODE_SPAN - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        low_idx = NODE_W'(i);
      end
    end
  end

  always_comb begin
    pre_st = STAT_OK;
    if (edge_cmd) begin
      if (!a_ok || !b_ok || ((cmd_r == CMD_ADD_EDGE) && (a_r == b_r))) begin
        pre_st = STAT_INVALID;
      end else if (!alive_r[a_idx] || !alive_r[b_idx]) begin
        pre_st = STAT_MISSING;
      end
    end else begin
      if (!a_ok) begin
        pre_st = STAT_INVALID;
      end else if (!alive_r[a_idx]) begin
        pre_st = STAT_MISSING;
      end
    end
  end

  // One write port and one read port; the sweep reads one row ahead of its write.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = a_idx;
    wr_data = row_cur ^ bit_b_vec;
    rd_en   = ctl.rd_a || ctl.rd_b;
    rd_addr = ctl.rd_b ? b_idx : a_idx;
    if (ctl.sweep) begin
      wr_en   = (sw_cnt_r != '0);
      wr_addr = IDX_W'(sw_cnt_r - 1'b1);
      wr_data = (wr_addr == a_idx) ? '0 : (row_cur & ~bit_a_vec);
      rd_en   = !sw_done;
      rd_addr = IDX_W'(sw_cnt_r);
    end else if (ctl.wr_a) begin
      wr_en   = 1'b1;
      wr_addr = a_idx;
      wr_data = row_cur ^ bit_b_vec;
    end else if (ctl.wr_b) begin
      wr_en   = 1'b1;
      wr_addr = b_idx;
      wr_data = row_cur ^ bit_a_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= rows_mem[rd_addr];
      rd_hit_r <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r    <= '0;
      alive_r      <= '1;
      node_count_r <= NODE_COUNT_RST;
      sw_cnt_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.kill) begin
        alive_r[a_idx] <= 1'b0;
        sw_cnt_r       <= '0;
      end else if (ctl.sweep && !sw_done) begin
        sw_cnt_r <= sw_cnt_r + 1'b1;
      end
      if (ctl.emit_single || ctl.emit_list) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      a_r   <= in_node_a;
      b_r   <= in_node_b;
    end
    if (ctl.set_status) begin
      status_r <= ctl.status_val;
    end
    if (ctl.load_list) begin
      pend_r <= row_vis;
    end else if (ctl.emit_list) begin
      pend_r <= pend_rest;
    end
    if (ctl.emit_single) begin
      out_status_r   <= status_r;
      out_neighbor_r <= '0;
      out_nvalid_r   <= 1'b0;
      out_last_r     <= 1'b1;
    end else if (ctl.emit_list) begin
      out_status_r   <= STAT_OK;
      out_neighbor_r <= low_idx;
      out_nvalid_r   <= 1'b1;
      out_last_r     <= (pend_rest == '0);
    end
  end

  assign sts.pre_st     = pre_st;
  assign sts.cmd        = cmd_r;
  assign sts.bit_ab     = row_cur[b_idx];
  assign sts.row_empty  = (row_vis == '0);
  assign sts.sweep_done = sw_done;
  assign sts.out_free   = out_free;
  assign sts.pend_last  = (pend_rest == '0);

  assign out_tvalid         = out_valid_r;
  assign out_status         = out_status_r;
  assign out_neighbor       = out_neighbor_r;
  assign out_neighbor_valid = out_nvalid_r;
  assign out_last           = out_last_r;

endmodule

// ===== hdl/ugadj_ctrl.sv =====
// Controller state machine that sequences each command through the datapath.
module ugadj_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  ugadj_pkg::ug_stat_t sts,
  output ugadj_pkg::ug_cmd_t  ctl
);
  import ugadj_pkg::*;

  ug_state_t state_r;
  ug_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.set_status = 1'b1;
        ctl.status_val = sts.pre_st;
        if (sts.pre_st != STAT_OK) begin
          state_nxt = S_RESP;
        end else if (sts.cmd == CMD_REM_NODE) begin
          ctl.kill  = 1'b1;
          state_nxt = S_SWEEP;
        end else begin
          ctl.rd_a  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (sts.cmd)
          CMD_ADD_EDGE: begin
            if (sts.bit_ab) begin
              ctl.set_status = 1'b1;
              ctl.status_val = STAT_CONNECTED;
              state_nxt      = S_RESP;
            end else begin
              ctl.wr_a  = 1'b1;
              ctl.rd_b  = 1'b1;
              state_nxt = S_WR_B;
            end
          end
          CMD_REM_EDGE: begin
            if (!sts.bit_ab) begin
              ctl.set_status = 1'b1;
              ctl.status_val = STAT_NO_EDGE;
              state_nxt      = S_RESP;
            end else begin
              ctl.wr_a  = 1'b1;
              ctl.rd_b  = 1'b1;
              state_nxt = S_WR_B;
            end
          end
          CMD_LIST: begin
            if (sts.row_empty) begin
              state_nxt = S_RESP;
            end else begin
              ctl.load_list = 1'b1;
              state_nxt     = S_LIST;
            end
          end
          default: begin
            state_nxt = S_RESP;
          end
        endcase
      end
      S_WR_B: begin
        ctl.wr_b  = 1'b1;
        state_nxt = S_RESP;
      end
      S_SWEEP: begin
        ctl.sweep = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_RESP;
        end
      end
      S_LIST: begin
        if (sts.out_free) begin
          ctl.emit_list = 1'b1;
          if (sts.pend_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.emit_single = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/undirected_graph_adjacency_table.sv =====
// Top level of the undirected graph adjacency table.
//
// The block keeps an undirected graph as a symmetric bit matrix, one row per
// node in a single-port-write memory, plus one alive flag per node. Commands
// arrive on the in_ stream: in_tuser carries the command kind and in_tdata
// the two node numbers. Every command returns a status on the out_ stream;
// a neighbor list returns one transfer per neighbor in ascending order, with
// out_tlast on the final one. The cfg_ port writes the node count at any
// clock edge where cfg_wr_en is high, and is meant to be used while idle.
// A command is taken only while the controller is idle. An edge command that
// changes the matrix reads and writes back both of its rows through the one
// memory port; one that finds the edge already present or missing skips the
// writes, and a rejected command skips the reads as well. Removing a node
// sweeps every row to clear its column. A list returns its neighbors one per
// cycle while the receiver accepts them. Results sit in an output register,
// so a new command can be accepted while the last result waits. When the
// receiver stalls, the result holds and the controller waits.
// Synchronous reset clears all edges, marks every node alive, sets the node
// count to sixteen and empties the output register; it needs no sweep.
module undirected_graph_adjacency_table #(
  parameter int MAX_NODES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,   // node_count
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [3:0] node_a, [7:4] node_b
  input  logic [1:0] in_tuser,      // [1:0] cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [2:0] status, [6:3] neighbor, [7] zero
  output logic [0:0] out_tuser,     // [0] neighbor_valid
  output logic       out_tlast
);
  import ugadj_pkg::*;

  ug_cmd_t           ctl;
  ug_stat_t          sts;
  logic [STAT_W-1:0] out_status;
  logic [NODE_W-1:0] out_neighbor;
  logic              out_neighbor_valid;

  ugadj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  ugadj_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_cmd             (in_tuser),
    .in_node_a          (in_tdata[3:0]),
    .in_node_b          (in_tdata[7:4]),
    .ctl                (ctl),
    .sts                (sts),
    .out_tready         (out_tready),
    .out_tvalid         (out_tvalid),
    .out_status         (out_status),
    .out_neighbor       (out_neighbor),
    .out_neighbor_valid (out_neighbor_valid),
    .out_last           (out_tlast)
  );

  assign out_tdata = {1'b0, out_neighbor, out_status};
  assign out_tuser = out_neighbor_valid;

`ifndef SYNTHESIS
  // A result without a neighbor is always the only or final one of its command.
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("result without neighbor not marked last");

  // The neighbor field is zero unless a neighbor is listed.
  a_neighbor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> (out_tdata[6:3] == 4'd0))
    else $error("neighbor field not zero");

  // The controller only loads a result when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_single || ctl.emit_list |-> !out_tvalid || out_tready)
    else $error("result overwritten before transfer");

  // At most one source drives the memory write port.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.wr_a, ctl.wr_b, ctl.sweep}))
    else $error("memory write port conflict");
`endif

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the undirected graph adjacency table.
module tb;
  import ugadj_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int SETTLE      = 24;    // longer than a remove-node sweep

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_a;
  } graph_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [NODE_W-1:0] neighbor;
    logic              listed;
    logic              last;
  } adj_answer_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CNT_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata = '0;
  logic [1:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [7:0]       out_tdata;
  logic [0:0]       out_tuser;
  logic             out_tlast;

  undirected_graph_adjacency_table dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the graph, updated when a command transfer is accepted.
  logic [NODE_SPAN-1:0] graph_rows [NODE_SPAN];
  logic [NODE_SPAN-1:0] node_live;
  logic [CNT_W-1:0]     node_limit;

  graph_cmd_t  cmd_queue [$];    // commands waiting to be sent
  adj_answer_t answers_due [$];  // results the block still owes

  int idle_pct = 0;      // chance per free slot that a sender gap or receiver stall starts
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int cmds_taken = 0;
  int answers_checked = 0;
  int neighbors_listed = 0;
  int settings_used = 1;
  graph_cmd_t  next_cmd;
  adj_answer_t got_answer;
  adj_answer_t want_answer;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, want,
             answers_checked);
    errors++;
  endtask

  task automatic owe_answer(input logic [STAT_W-1:0] st, input logic [NODE_W-1:0] nb,
                            input logic listed, input logic last);
    adj_answer_t ans;
    ans.status   = st;
    ans.neighbor = nb;
    ans.listed   = listed;
    ans.last     = last;
    answers_due.push_back(ans);
  endtask

  // Applies one command to the shadow graph and queues the results it causes.
  task automatic model_graph_command(input logic [CMD_W-1:0] op,
                                     input logic [NODE_W-1:0] na,
                                     input logic [NODE_W-1:0] nb);
    int span;
    int n;
    logic [STAT_W-1:0] st;
    logic [NODE_SPAN-1:0] row;
    span = (node_limit > NODE_SPAN) ? NODE_SPAN : int'(node_limit);
    st = STAT_OK;
    if (op == CMD_ADD_EDGE || op == CMD_REM_EDGE) begin
      if (na >= span || nb >= span || (op == CMD_ADD_EDGE && na == nb)) begin
        st = STAT_INVALID;
      end else if (!node_live[na] || !node_live[nb]) begin
        st = STAT_MISSING;
      end else if (op == CMD_ADD_EDGE) begin
        if (graph_rows[na][nb]) begin
          st = STAT_CONNECTED;
        end else begin
          graph_rows[na][nb] = 1'b1;
          graph_rows[nb][na] = 1'b1;
        end
      end else if (!graph_rows[na][nb]) begin
        st = STAT_NO_EDGE;
      end else begin
        graph_rows[na][nb] = 1'b0;
        graph_rows[nb][na] = 1'b0;
      end
      owe_answer(st, '0, 1'b0, 1'b1);
    end else if (na >= span) begin
      owe_answer(STAT_INVALID, '0, 1'b0, 1'b1);
    end else if (!node_live[na]) begin
      owe_answer(STAT_MISSING, '0, 1'b0, 1'b1);
    end else if (op == CMD_REM_NODE) begin
      node_live[na] = 1'b0;
      graph_rows[na] = '0;
      for (int i = 0; i < NODE_SPAN; i++) graph_rows[i][na] = 1'b0;
      owe_answer(STAT_OK, '0, 1'b0, 1'b1);
    end else begin
      // Edges to nodes at or above the current count stay stored but are not listed.
      row = graph_rows[na] & NODE_SPAN'((32'd1 << span) - 1);
      n = 0;
      for (int i = 0; i < NODE_SPAN; i++) begin
        if (row[i]) begin
          row[i] = 1'b0;
          owe_answer(STAT_OK, NODE_W'(i), 1'b1, row == '0);
          n++;
        end
      end
      if (n == 0) owe_answer(STAT_OK, '0, 1'b0, 1'b1);
    end
  endtask

  // Command driver: holds each transfer until accepted, with random gaps between.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
      for (int i = 0; i < NODE_SPAN; i++) graph_rows[i] = '0;
      node_live = '1;
      node_limit = NODE_COUNT_RST;
    end else begin
      if (in_tvalid && in_tready) begin
        model_graph_command(in_tuser, in_tdata[3:0], in_tdata[7:4]);
        cmds_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_queue.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(0, 10);
          in_tvalid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          next_cmd = cmd_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {next_cmd.node_b, next_cmd.node_a};
          in_tuser  <= next_cmd.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks every accepted result against the oldest one owed.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_answer = {out_tdata[2:0], out_tdata[6:3], out_tuser[0], out_tlast};
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing owed, tdata", out_tdata, 0);
        end else begin
          want_answer = answers_due.pop_front();
          if (got_answer.status !== want_answer.status)
            report_mismatch("status", got_answer.status, want_answer.status);
          if (got_answer.neighbor !== want_answer.neighbor)
            report_mismatch("neighbor", got_answer.neighbor, want_answer.neighbor);
          if (got_answer.listed !== want_answer.listed)
            report_mismatch("neighbor_valid", got_answer.listed, want_answer.listed);
          if (got_answer.last !== want_answer.last)
            report_mismatch("last", got_answer.last, want_answer.last);
          if (want_answer.listed) neighbors_listed++;
        end
        answers_checked++;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which neither side completes a transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("undirected_graph_adjacency_table verification failed");
      $finish;
    end
  end

  task automatic queue_cmd(input logic [CMD_W-1:0] op, input int na, input int nb);
    graph_cmd_t c;
    c.op     = op;
    c.node_a = NODE_W'(na);
    c.node_b = NODE_W'(nb);
    cmd_queue.push_back(c);
  endtask

  // Mostly a node in range for the current count, sometimes any node number.
  function automatic int pick_node();
    int span;
    span = (node_limit > NODE_SPAN) ? NODE_SPAN : int'(node_limit);
    if (span > 0 && $urandom_range(0, 9) < 8) return $urandom_range(0, span - 1);
    return $urandom_range(0, NODE_SPAN - 1);
  endfunction

  // Random traffic: about three in ten draws start a short connect/list/disconnect sequence.
  task automatic queue_random(input int total);
    int made;
    int a;
    int b;
    int r;
    logic [CMD_W-1:0] op;
    made = 0;
    while (made < total) begin
      a = pick_node();
      b = pick_node();
      if ($urandom_range(0, 9) < 3) begin
        queue_cmd(CMD_ADD_EDGE, a, b);
        queue_cmd(CMD_LIST, a, $urandom_range(0, 15));
        made += 2;
        if ($urandom_range(0, 1) == 1) begin
          queue_cmd(CMD_REM_EDGE, b, a);
          queue_cmd(CMD_LIST, b, $urandom_range(0, 15));
          made += 2;
        end
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40) op = CMD_ADD_EDGE;
        else if (r < 62) op = CMD_REM_EDGE;
        else if (r < 98) op = CMD_LIST;
        else op = CMD_REM_NODE;
        if ($urandom_range(0, 9) == 0) b = a;
        queue_cmd(op, a, b);
        made++;
      end
    end
  endtask

  // The sender is held off until every owed result has come and the block has settled.
  task automatic wait_for_drain();
    @(negedge clk);
    while (cmd_queue.size() != 0 || in_tvalid || answers_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_node_count(input logic [CNT_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    node_limit = value;
    settings_used++;
    @(negedge clk);
  endtask

  // One phase: new node count, a list of node 0 to show hidden edges, then random traffic.
  task automatic run_phase(input logic [CNT_W-1:0] count, input int pct, input int total);
    write_node_count(count);
    idle_pct = pct;
    queue_cmd(CMD_LIST, 0, 15);
    queue_random(total);
    wait_for_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_pct = 30;

    // Directed opening at the reset count of sixteen.
    queue_cmd(CMD_ADD_EDGE, 0, 15);
    queue_cmd(CMD_ADD_EDGE, 15, 0);   // already connected
    queue_cmd(CMD_ADD_EDGE, 3, 3);    // equal endpoints on add
    queue_cmd(CMD_REM_EDGE, 5, 5);    // no self edge to remove
    queue_cmd(CMD_REM_EDGE, 2, 7);    // edge never added
    queue_cmd(CMD_LIST, 4, 9);        // list with no neighbors
    for (int i = 1; i < 15; i++) queue_cmd(CMD_ADD_EDGE, 0, i);
    queue_cmd(CMD_LIST, 0, 0);        // longest possible list
    queue_cmd(CMD_REM_EDGE, 0, 15);
    queue_cmd(CMD_REM_NODE, 9, 0);
    queue_cmd(CMD_LIST, 9, 0);        // removed node
    queue_cmd(CMD_ADD_EDGE, 9, 3);    // edge to a removed node
    queue_cmd(CMD_LIST, 0, 0);        // removed node gone from the row
    wait_for_drain();

    queue_random(130);
    wait_for_drain();

    run_phase(5'd5, 30, 60);   // lowered count hides edges, invalid nodes appear
    run_phase(5'd0, 20, 20);   // every node number invalid
    run_phase(5'd31, 0, 70);   // saturates at the full span, no idling
    run_phase(5'd1, 50, 20);
    run_phase(5'd2, 30, 30);
    run_phase(5'd11, 25, 50);
    run_phase(5'd16, 0, 60);   // final stretch at full rate

    if (answers_due.size() != 0)
      report_mismatch("results never delivered", 0, answers_due.size());
    $display("run covered %0d commands over %0d node-count settings", cmds_taken,
             settings_used);
    $display("checked %0d results, %0d of them listed neighbors, %0d mismatches",
             answers_checked, neighbors_listed, errors);
    if (errors == 0) begin
      $display("undirected_graph_adjacency_table verification clean");
    end else begin
      $display("undirected_graph_adjacency_table verification failed");
    end
    $finish;
  end

endmodule
